// File: hw/rtl/superio_config_port_decoder_assert.svh
// Assertion macros used by the configuration port decoder controller (siocfg_ctrl).
`ifndef SUPERIO_CONFIG_PORT_DECODER_ASSERT_SVH
`define SUPERIO_CONFIG_PORT_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIOCFG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIOCFG_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/siocfg_pkg.sv
package siocfg_pkg;

    // Bus access fields
    localparam logic OP_READ    = 1'b0;
    localparam logic OP_WRITE   = 1'b1;
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    // Lock sequence keys written to the index port
    localparam logic [7:0] KEY_UNLOCK = 8'h55;
    localparam logic [7:0] KEY_LOCK   = 8'hAA;

    // Configuration port
    localparam int unsigned PADDR_W = 2;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_IDE_CHANNEL = 2'd0;

    // IDE channel codes
    localparam logic [1:0] IDE_NONE      = 2'd0;
    localparam logic [1:0] IDE_PRIMARY   = 2'd1;
    localparam logic [1:0] IDE_SECONDARY = 2'd2;

    // Register file reset contents
    localparam logic [7:0] REG0_RST = 8'h3f;
    localparam logic [7:0] REG1_RST = 8'h9f;
    localparam logic [7:0] REG2_RST = 8'hdc;

    // Serial port selection codes
    localparam logic [1:0] SER_PRIMARY   = 2'd0;
    localparam logic [1:0] SER_SECONDARY = 2'd1;
    localparam logic [1:0] SER_ALT_A     = 2'd2;
    localparam logic [1:0] SER_ALT_B     = 2'd3;

    // Parallel port selection codes
    localparam logic [1:0] LPT_OFF = 2'd0;
    localparam logic [1:0] LPT_3BC = 2'd1;
    localparam logic [1:0] LPT_378 = 2'd2;
    localparam logic [1:0] LPT_278 = 2'd3;

    localparam logic [9:0] SER_PRIMARY_BASE   = 10'h3f8;
    localparam logic [9:0] SER_SECONDARY_BASE = 10'h2f8;
    localparam logic [2:0] IRQ_4              = 3'd4;
    localparam logic [2:0] IRQ_3              = 3'd3;

    localparam logic [9:0] ALT_A_BASE [4] = '{10'h338, 10'h3e8, 10'h3e8, 10'h220};
    localparam logic [9:0] ALT_B_BASE [4] = '{10'h238, 10'h2e8, 10'h2e0, 10'h228};

    typedef struct packed {
        logic       op;
        logic       port_sel;
        logic [7:0] wdata;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       config_mode;
        logic       com_a_enable;
        logic [9:0] com_a_base;
        logic [2:0] com_a_irq;
        logic       com_b_enable;
        logic [9:0] com_b_base;
        logic [2:0] com_b_irq;
        logic       lpt_enable;
        logic [9:0] lpt_base;
        logic       fdc_enable;
        logic       ide_active;
    } rsp_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic idx_wr;
        logic file_wr;
        logic file_rd;
        logic cfg_wr;
        logic config_mode;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_write;
        logic is_data;
        logic unlock_key;
        logic lock_key;
    } sts_t;

    typedef struct packed {
        logic [9:0] base;
        logic [2:0] irq;
    } ser_res_t;

    // Decode one serial port's selection against the alternate address pair
    function automatic ser_res_t serial_decode(input logic [1:0] sel, input logic [1:0] alt);
        ser_res_t res;
        unique case (sel)
            SER_PRIMARY:   res = '{base: SER_PRIMARY_BASE,   irq: IRQ_4};
            SER_SECONDARY: res = '{base: SER_SECONDARY_BASE, irq: IRQ_3};
            SER_ALT_A:     res = '{base: ALT_A_BASE[alt],    irq: IRQ_4};
            default:       res = '{base: ALT_B_BASE[alt],    irq: IRQ_3};
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/superio_config_port_decoder.sv
// Index/data configuration port decoder for a super I/O block.
// req channel: one bus access per transfer (op, port_sel, wdata) on
// req_valid/req_ready. rsp channel: one result per access on
// rsp_valid/rsp_ready, carrying the read byte, the unlock state and the
// decoded serial, parallel, floppy and IDE resources after the access.
// Two index writes of 0x55 unlock the port, an index write of 0xAA locks it.
// The result is registered when the access is accepted. Throughput is one
// access per cycle while results are taken: the single result register
// refills in the cycle it is drained. When the receiver stalls, the result
// holds and req_ready drops until it is taken. The APB port holds the IDE
// channel register at address 0; the user must write it only while no
// access is in flight, which the block does not enforce. pready is always
// high. Reset locks the port, clears the index and loads the register file
// with its power-on contents (0x3f, 0x9f, 0xdc, rest zero); no clearing pass.
module superio_config_port_decoder #(
    parameter int unsigned NUM_REGS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  siocfg_pkg::req_t               req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output siocfg_pkg::rsp_t               rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [siocfg_pkg::PADDR_W-1:0] paddr,
    input  logic [siocfg_pkg::PDATA_W-1:0] pwdata,
    output logic [siocfg_pkg::PDATA_W-1:0] prdata,
    output logic                           pready
);
    import siocfg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;

    siocfg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .sts       (sts),
        .cmd       (cmd)
    );

    siocfg_dp #(
        .NUM_REGS (NUM_REGS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

// File: hw/rtl/siocfg_ctrl.sv
module siocfg_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [siocfg_pkg::PADDR_W-1:0] paddr,
    input  siocfg_pkg::sts_t               sts,
    output siocfg_pkg::cmd_t               cmd
);
    import siocfg_pkg::*;

    `include "superio_config_port_decoder_assert.svh"

    typedef enum logic [1:0] {
        OUT_EMPTY = 2'b01,
        OUT_FULL  = 2'b10
    } out_state_t;

    typedef enum logic [2:0] {
        LK_IDLE = 3'b001,
        LK_HALF = 3'b010,
        LK_OPEN = 3'b100
    } lock_state_t;

    out_state_t  out_state_reg, out_state_next;
    lock_state_t lock_state_reg, lock_state_next;
    logic        accept;
    logic        idx_port_wr;
    logic        is_open;

    // Take a new transfer when the result register is empty or draining
    assign req_ready   = (out_state_reg == OUT_EMPTY) || rsp_ready;
    assign rsp_valid   = (out_state_reg == OUT_FULL);
    assign accept      = req_valid && req_ready;
    assign idx_port_wr = sts.is_write && !sts.is_data;
    assign is_open     = (lock_state_reg == LK_OPEN);

    // Track result register occupancy
    always_comb
    begin
        out_state_next = out_state_reg;
        unique case (out_state_reg)
            OUT_EMPTY:
            begin
                if (accept)
                    out_state_next = OUT_FULL;
            end
            OUT_FULL:
            begin
                if (!accept && rsp_ready)
                    out_state_next = OUT_EMPTY;
            end
            default: out_state_next = OUT_EMPTY;
        endcase
    end

    // Advance the unlock sequence, or relock the port, on index port writes
    always_comb
    begin
        lock_state_next = lock_state_reg;
        if (accept && idx_port_wr)
        begin
            unique case (lock_state_reg)
                LK_IDLE:
                begin
                    if (sts.unlock_key)
                        lock_state_next = LK_HALF;
                end
                LK_HALF:
                begin
                    if (sts.unlock_key)
                        lock_state_next = LK_OPEN;
                end
                LK_OPEN:
                begin
                    if (sts.lock_key)
                        lock_state_next = LK_IDLE;
                end
                default: lock_state_next = LK_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_state_reg  <= OUT_EMPTY;
            lock_state_reg <= LK_IDLE;
        end
        else
        begin
            out_state_reg  <= out_state_next;
            lock_state_reg <= lock_state_next;
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.load        = accept;
        cmd.idx_wr      = accept && is_open && idx_port_wr && !sts.lock_key;
        cmd.file_wr     = accept && is_open && sts.is_write && sts.is_data;
        cmd.file_rd     = accept && is_open && !sts.is_write && sts.is_data;
        cmd.cfg_wr      = psel && penable && pwrite && (paddr == ADDR_IDE_CHANNEL);
        cmd.config_mode = is_open;
    end

    `SIOCFG_ASSERT_NXT(a_lock_on_key, clk, rst_n,
        accept && is_open && idx_port_wr && sts.lock_key,
        lock_state_reg == LK_IDLE, "lock key did not relock the port")
    `SIOCFG_ASSERT_IMP(a_file_access_open, clk, rst_n,
        cmd.file_wr || cmd.file_rd || cmd.idx_wr,
        is_open, "register access while locked")
    `SIOCFG_ASSERT_IMP(a_no_overwrite, clk, rst_n,
        accept && rsp_valid,
        rsp_ready, "result overwritten before transfer")
    `SIOCFG_ASSERT_NXT(a_result_follows, clk, rst_n,
        accept,
        rsp_valid, "accepted transfer produced no result")

endmodule

// File: hw/rtl/siocfg_dp.sv
module siocfg_dp #(
    parameter int unsigned NUM_REGS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  siocfg_pkg::req_t               req,
    output siocfg_pkg::rsp_t               rsp,
    input  logic [siocfg_pkg::PADDR_W-1:0] paddr,
    input  logic [siocfg_pkg::PDATA_W-1:0] pwdata,
    output logic [siocfg_pkg::PDATA_W-1:0] prdata,
    input  siocfg_pkg::cmd_t               cmd,
    output siocfg_pkg::sts_t               sts
);
    import siocfg_pkg::*;

    localparam int unsigned IDX_W = $clog2(NUM_REGS);

    logic [7:0]       file_reg [NUM_REGS];
    logic [7:0]       index_reg;
    logic [1:0]       ide_reg;
    logic [7:0]       read_data_reg, read_data_next;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [7:0]       r0, r1, r2;
    ser_res_t         com_a, com_b;

    // Decode the incoming access for the controller
    assign sts.is_write   = (req.op == OP_WRITE);
    assign sts.is_data    = (req.port_sel == PORT_DATA);
    assign sts.unlock_key = (req.wdata == KEY_UNLOCK);
    assign sts.lock_key   = (req.wdata == KEY_LOCK);

    assign in_range = (index_reg < 8'(NUM_REGS));
    assign idx      = index_reg[IDX_W-1:0];

    // Select read data for an unlocked data port read
    assign read_data_next = (cmd.file_rd && in_range) ? file_reg[idx] : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_reg[0] <= REG0_RST;
            file_reg[1] <= REG1_RST;
            file_reg[2] <= REG2_RST;
            for (int i = 3; i < NUM_REGS; i++)
                file_reg[i] <= 8'h00;
            index_reg   <= 8'h00;
            ide_reg     <= IDE_NONE;
        end
        else
        begin
            if (cmd.file_wr && in_range)
                file_reg[idx] <= req.wdata;
            if (cmd.idx_wr)
                index_reg <= req.wdata;
            if (cmd.cfg_wr)
                ide_reg <= pwdata[1:0];
        end
    end

    // Hold read data with the result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            read_data_reg <= read_data_next;
    end

    assign prdata = (paddr == ADDR_IDE_CHANNEL) ? {{(PDATA_W-2){1'b0}}, ide_reg} : '0;

    // Decode resources from registers 0 to 2
    assign r0    = file_reg[0];
    assign r1    = file_reg[1];
    assign r2    = file_reg[2];
    assign com_a = serial_decode(r2[1:0], r1[6:5]);
    assign com_b = serial_decode(r2[5:4], r1[6:5]);

    always_comb
    begin
        rsp.read_data    = read_data_reg;
        rsp.config_mode  = cmd.config_mode;
        rsp.com_a_enable = r2[2];
        rsp.com_a_base   = r2[2] ? com_a.base : 10'd0;
        rsp.com_a_irq    = r2[2] ? com_a.irq : 3'd0;
        rsp.com_b_enable = r2[6];
        rsp.com_b_base   = r2[6] ? com_b.base : 10'd0;
        rsp.com_b_irq    = r2[6] ? com_b.irq : 3'd0;
        rsp.lpt_enable   = (r1[1:0] != LPT_OFF);
        case (r1[1:0])
            LPT_3BC: rsp.lpt_base = 10'h3bc;
            LPT_378: rsp.lpt_base = 10'h378;
            LPT_278: rsp.lpt_base = 10'h278;
            default: rsp.lpt_base = 10'd0;
        endcase
        rsp.fdc_enable   = r0[4];
        rsp.ide_active   = ((ide_reg == IDE_PRIMARY) || (ide_reg == IDE_SECONDARY)) && r0[0];
    end

endmodule

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import siocfg_pkg::*;

    // Unlock counter value at which the port is open
    localparam logic [1:0] UNLOCKED     = 2'd2;
    // IDE channel code outside the defined set, decodes as no IDE
    localparam logic [1:0] IDE_RESERVED = 2'd3;
    localparam int unsigned FILE_DEPTH  = 16;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Shadow copy of the decoder state
    logic [1:0]           shadow_unlock;
    logic [7:0]           shadow_index;
    logic [7:0]           shadow_file [FILE_DEPTH];
    logic [1:0]           shadow_ide;

    rsp_t                 expected_rsp [$];
    int unsigned          mismatch_count = 0;
    int unsigned          accesses_sent  = 0;
    int unsigned          burst_left     = 0;
    int unsigned          gap_max        = 4;
    int unsigned          stall_mode     = 1;
    int unsigned          stall_left     = 0;

    superio_config_port_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Map a serial port selection to its base and interrupt line
    function automatic void serial_lookup(input logic [1:0] sel, input logic [1:0] alt,
                                          output logic [9:0] base, output logic [2:0] irq);
        logic [9:0] alt_a;
        logic [9:0] alt_b;
        case (alt)
            2'd0:    begin alt_a = 10'h338; alt_b = 10'h238; end
            2'd1:    begin alt_a = 10'h3e8; alt_b = 10'h2e8; end
            2'd2:    begin alt_a = 10'h3e8; alt_b = 10'h2e0; end
            default: begin alt_a = 10'h220; alt_b = 10'h228; end
        endcase
        case (sel)
            SER_PRIMARY:   begin base = 10'h3f8; irq = 3'd4; end
            SER_SECONDARY: begin base = 10'h2f8; irq = 3'd3; end
            SER_ALT_A:     begin base = alt_a;   irq = 3'd4; end
            default:       begin base = alt_b;   irq = 3'd3; end
        endcase
    endfunction

    // Apply one bus access to the shadow state and decode the resources
    function rsp_t decode_access(input req_t a);
        rsp_t       r;
        logic [7:0] r0;
        logic [7:0] r1;
        logic [7:0] r2;
        logic [9:0] base;
        logic [2:0] irq;
        r = '0;
        if (shadow_unlock == UNLOCKED) begin
            if (a.op == OP_WRITE) begin
                if (a.port_sel == PORT_INDEX) begin
                    if (a.wdata == KEY_LOCK)
                        shadow_unlock = '0;
                    else
                        shadow_index = a.wdata;
                end
                else if (shadow_index < FILE_DEPTH) begin
                    shadow_file[shadow_index[3:0]] = a.wdata;
                end
            end
            else if (a.port_sel == PORT_DATA && shadow_index < FILE_DEPTH) begin
                r.read_data = shadow_file[shadow_index[3:0]];
            end
        end
        else if (a.op == OP_WRITE && a.port_sel == PORT_INDEX && a.wdata == KEY_UNLOCK) begin
            shadow_unlock = shadow_unlock + 2'd1;
        end

        r0 = shadow_file[0];
        r1 = shadow_file[1];
        r2 = shadow_file[2];
        r.config_mode = (shadow_unlock == UNLOCKED);

        r.com_a_enable = r2[2];
        if (r2[2]) begin
            serial_lookup(r2[1:0], r1[6:5], base, irq);
            r.com_a_base = base;
            r.com_a_irq  = irq;
        end
        r.com_b_enable = r2[6];
        if (r2[6]) begin
            serial_lookup(r2[5:4], r1[6:5], base, irq);
            r.com_b_base = base;
            r.com_b_irq  = irq;
        end

        r.lpt_enable = (r1[1:0] != LPT_OFF);
        case (r1[1:0])
            LPT_3BC: r.lpt_base = 10'h3bc;
            LPT_378: r.lpt_base = 10'h378;
            LPT_278: r.lpt_base = 10'h278;
            default: r.lpt_base = '0;
        endcase

        r.fdc_enable = r0[4];
        r.ide_active = (shadow_ide == IDE_PRIMARY || shadow_ide == IDE_SECONDARY) && r0[0];
        return r;
    endfunction

    // Drive one access and hold it until the transfer; bursts with random gaps
    task automatic send_access(input req_t a);
        int unsigned gap;
        req       <= a;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        expected_rsp.push_back(decode_access(a));
        accesses_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            gap = $urandom_range(gap_max, 0);
            if (gap != 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else begin
            burst_left--;
        end
    endtask

    task automatic write_index(input logic [7:0] value);
        req_t a;
        a.op       = OP_WRITE;
        a.port_sel = PORT_INDEX;
        a.wdata    = value;
        send_access(a);
    endtask

    task automatic write_data(input logic [7:0] value);
        req_t a;
        a.op       = OP_WRITE;
        a.port_sel = PORT_DATA;
        a.wdata    = value;
        send_access(a);
    endtask

    task automatic read_port(input logic port);
        req_t a;
        a.op       = OP_READ;
        a.port_sel = port;
        a.wdata    = 8'($urandom);
        send_access(a);
    endtask

    task automatic send_any;
        req_t a;
        a.op       = 1'($urandom);
        a.port_sel = 1'($urandom);
        a.wdata    = 8'($urandom);
        send_access(a);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_idle;
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // APB write of the IDE channel register: setup cycle, then access cycle
    task automatic write_ide_channel(input logic [1:0] value);
        logic [PDATA_W-1:0] word;
        word      = PDATA_W'($urandom);
        word[1:0] = value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_IDE_CHANNEL;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_ide = value;
    endtask

    // Register index: mostly the decoded registers, some of the file, some out of range
    function automatic logic [7:0] pick_index;
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 60)
            return 8'($urandom_range(2, 0));
        else if (roll < 85)
            return 8'($urandom_range(FILE_DEPTH - 1, 0));
        else
            return 8'($urandom_range(255, FILE_DEPTH));
    endfunction

    // Reset contents, lock sequence, out-of-range index and decode extremes
    task automatic test_directed;
        read_port(PORT_DATA);
        write_data(KEY_UNLOCK);
        write_index(KEY_UNLOCK);
        write_index(8'h00);
        write_index(KEY_UNLOCK);
        read_port(PORT_INDEX);
        read_port(PORT_DATA);
        write_index(8'h0f);
        write_data(8'hff);
        read_port(PORT_DATA);
        write_index(8'h10);
        write_data(8'h12);
        read_port(PORT_DATA);
        write_index(8'hff);
        write_index(8'h02);
        write_data(8'h00);
        write_data(8'hff);
        write_index(8'h01);
        write_data(8'h00);
        write_data(8'hff);
        write_index(KEY_LOCK);
        read_port(PORT_DATA);
        write_index(KEY_UNLOCK);
        write_index(KEY_UNLOCK);
        read_port(PORT_DATA);
    endtask

    // Unlock, random register traffic, usually lock again; some plain noise
    task automatic test_sessions(input int unsigned count);
        int unsigned target;
        int unsigned ops;
        target = accesses_sent + count;
        while (accesses_sent < target) begin
            if ($urandom_range(9, 0) < 8) begin
                write_index(KEY_UNLOCK);
                if ($urandom_range(5, 0) == 0)
                    send_any();
                write_index(KEY_UNLOCK);
                ops = $urandom_range(12, 1);
                repeat (ops) begin
                    case ($urandom_range(9, 0))
                        0, 1, 2: write_index(pick_index());
                        3, 4, 5: write_data(8'($urandom));
                        6, 7, 8: read_port(PORT_DATA);
                        default: read_port(PORT_INDEX);
                    endcase
                end
                if ($urandom_range(9, 0) < 7)
                    write_index(KEY_LOCK);
            end
            else begin
                repeat ($urandom_range(6, 1)) send_any();
            end
        end
    endtask

    // Fully random accesses, locked or not
    task automatic test_noise(input int unsigned count);
        repeat (count) send_any();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
                mismatch_count++;
                $display("%0t ns unexpected result: expected none, actual %h", $time, rsp);
            end
            else begin
                want = expected_rsp.pop_front();
                check_field("read_data",    32'(want.read_data),    32'(rsp.read_data));
                check_field("config_mode",  32'(want.config_mode),  32'(rsp.config_mode));
                check_field("com_a_enable", 32'(want.com_a_enable), 32'(rsp.com_a_enable));
                check_field("com_a_base",   32'(want.com_a_base),   32'(rsp.com_a_base));
                check_field("com_a_irq",    32'(want.com_a_irq),    32'(rsp.com_a_irq));
                check_field("com_b_enable", 32'(want.com_b_enable), 32'(rsp.com_b_enable));
                check_field("com_b_base",   32'(want.com_b_base),   32'(rsp.com_b_base));
                check_field("com_b_irq",    32'(want.com_b_irq),    32'(rsp.com_b_irq));
                check_field("lpt_enable",   32'(want.lpt_enable),   32'(rsp.lpt_enable));
                check_field("lpt_base",     32'(want.lpt_base),     32'(rsp.lpt_base));
                check_field("fdc_enable",   32'(want.fdc_enable),   32'(rsp.fdc_enable));
                check_field("ide_active",   32'(want.ide_active),   32'(rsp.ide_active));
            end
        end
    end

    // Receiver: alternate ready and stall stretches; mode 0 never stalls
    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            stall_left--;
        end
        else if (stall_mode == 0) begin
            rsp_ready <= 1'b1;
        end
        else if (rsp_ready) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(stall_mode == 2 ? 12 : 2, 0);
        end
        else begin
            rsp_ready  <= 1'b1;
            stall_left = $urandom_range(20, 1);
        end
    end

    initial
    begin
        shadow_unlock = '0;
        shadow_index  = '0;
        shadow_ide    = IDE_NONE;
        foreach (shadow_file[i])
            shadow_file[i] = '0;
        shadow_file[0] = REG0_RST;
        shadow_file[1] = REG1_RST;
        shadow_file[2] = REG2_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_ide_channel(IDE_NONE);
        test_directed();
        wait_idle();

        write_ide_channel(IDE_PRIMARY);
        gap_max    = 0;
        stall_mode = 0;
        test_sessions(150);
        wait_idle();

        write_ide_channel(IDE_SECONDARY);
        gap_max    = 4;
        stall_mode = 1;
        test_sessions(150);
        wait_idle();

        write_ide_channel(IDE_RESERVED);
        gap_max    = 8;
        stall_mode = 2;
        test_sessions(150);
        wait_idle();

        write_ide_channel(IDE_NONE);
        gap_max    = 3;
        stall_mode = 1;
        test_noise(50);
        test_sessions(100);
        wait_idle();

        write_ide_channel(IDE_PRIMARY);
        test_sessions(50);
        wait_idle();
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS superio_config_port_decoder");
        else
            $display("FAIL superio_config_port_decoder");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL superio_config_port_decoder");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/siocfg_pkg.sv
hw/rtl/siocfg_ctrl.sv
hw/rtl/siocfg_dp.sv
hw/rtl/superio_config_port_decoder.sv
bench/tb.sv
